// ===== src/lud_pkg.sv =====
// ----------------------------------------------------------------------------
// lud_pkg: shared types, constants and fixed-point helpers
// Q8.24 saturating multiply/add used by the undistortion pipeline.
// ----------------------------------------------------------------------------
package lud_pkg;

    localparam int ITERATIONS = 5;
    localparam int FRAC_BITS  = 24;
    localparam int DW         = 32;
    // quotient of 2^(2F)/den needs QBITS bits once den > 2^DIV_LO
    localparam int QBITS      = DW - 1;
    localparam int DIV_LO     = 2 * FRAC_BITS - QBITS;
    localparam int ITER_LAT   = 6 + QBITS + 1;
    localparam int CFG_AW     = 3;

    typedef enum logic [CFG_AW-1:0] {
        REG_K1 = 3'd0,
        REG_K2 = 3'd1,
        REG_P1 = 3'd2,
        REG_P2 = 3'd3,
        REG_K3 = 3'd4
    } t_reg_idx;

    typedef logic signed [DW-1:0] t_fix;

    typedef struct packed {
        t_fix k1;
        t_fix k2;
        t_fix p1;
        t_fix p2;
        t_fix k3;
    } t_coef;

    // point state travelling through the iterations
    typedef struct packed {
        t_fix x0;
        t_fix y0;
        t_fix x;
        t_fix y;
        logic fb;
        logic skip;
    } t_pt;

    localparam t_fix FIX_ONE = t_fix'(64'sd1 <<< FRAC_BITS);
    localparam t_fix FIX_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam t_fix FIX_MIN = {1'b1, {(DW-1){1'b0}}};

    function automatic t_fix sat32(input logic signed [63:0] v);
        t_fix r;
        if (v > 64'(FIX_MAX)) begin
            r = FIX_MAX;
        end else if (v < 64'(FIX_MIN)) begin
            r = FIX_MIN;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    // product floored at the binary point, saturated
    function automatic t_fix fmul(input t_fix a, input t_fix b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat32(p >>> FRAC_BITS);
    endfunction

    function automatic t_fix fadd(input t_fix a, input t_fix b);
        return sat32(64'(a) + 64'(b));
    endfunction

    function automatic t_fix fsub(input t_fix a, input t_fix b);
        return sat32(64'(a) - 64'(b));
    endfunction

endpackage

// ===== src/lens_undistort_point_iterative.sv =====
// Throughput: one point per cycle; each iteration is its own pipeline section
// and the inverse factor comes from a 31-stage restoring divider, one bit per stage.
// A stall at the output holds every stage in place (single pipeline enable).
// Reset (i_rst_n low, synchronous) clears all valid bits and the coefficients to 0.
// ----------------------------------------------------------------------------
// lens_undistort_point_iterative: Brown-Conrady point undistortion
// Five unrolled fixed-point correction iterations in signed Q8.24 with
// saturation; falls back to the input point on a non-positive denominator.
// ----------------------------------------------------------------------------
module lens_undistort_point_iterative
    import lud_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [DW-1:0]     i_cfg_data,
    // input transaction
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [2*DW-1:0]   i_s_tdata,   // [31:0] x_in, [63:32] y_in
    // output transaction
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [2*DW-1:0]   o_m_tdata,   // [31:0] x_out, [63:32] y_out
    output logic              o_m_tuser    // [0] fell_back
);

    t_coef r_coef;
    logic  ce;
    logic  r_o_valid;
    t_pt   r_o_pt;
    logic  w_v  [ITERATIONS+1];
    t_pt   w_pt [ITERATIONS+1];

    // coefficient registers; out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_K1:  r_coef.k1 <= i_cfg_data;
                REG_K2:  r_coef.k2 <= i_cfg_data;
                REG_P1:  r_coef.p1 <= i_cfg_data;
                REG_P2:  r_coef.p2 <= i_cfg_data;
                REG_K3:  r_coef.k3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline advances unless a finished result is waiting
    assign ce         = !r_o_valid || i_m_tready;
    assign o_s_tready = ce;

    // entry: all-zero coefficients mark the point as pass-through
    assign w_v[0]       = i_s_tvalid;
    assign w_pt[0].x0   = i_s_tdata[DW-1:0];
    assign w_pt[0].y0   = i_s_tdata[2*DW-1:DW];
    assign w_pt[0].x    = i_s_tdata[DW-1:0];
    assign w_pt[0].y    = i_s_tdata[2*DW-1:DW];
    assign w_pt[0].fb   = 1'b0;
    assign w_pt[0].skip = (r_coef == '0);

    for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
        lud_iter u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_coef  (r_coef),
            .i_valid (w_v[i]),
            .i_pt    (w_pt[i]),
            .o_valid (w_v[i+1]),
            .o_pt    (w_pt[i+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ce) begin
            r_o_valid <= w_v[ITERATIONS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_o_pt <= w_pt[ITERATIONS];
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {r_o_pt.y, r_o_pt.x};
    assign o_m_tuser  = r_o_pt.fb;

`ifndef SYNTHESIS
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_o_valid)
        else $error("output valid not cleared by reset");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while output stalled");

    a_fallback_restores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_pt.fb) |-> (r_o_pt.x == r_o_pt.x0 && r_o_pt.y == r_o_pt.y0))
        else $error("fallback result differs from input point");

    a_skip_no_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_pt.skip) |-> (!r_o_pt.fb && r_o_pt.x == r_o_pt.x0))
        else $error("pass-through point was modified");
`endif

endmodule

// ===== src/lud_iter.sv =====
// ----------------------------------------------------------------------------
// lud_iter: one unrolled correction iteration
// Polynomial and tangential terms over six stages, a one-bit-per-stage
// restoring divider for the inverse factor, then the final scaling.
// ----------------------------------------------------------------------------
module lud_iter
    import lud_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_ce,
    input  t_coef i_coef,
    input  logic  i_valid,
    input  t_pt   i_pt,
    output logic  o_valid,
    output t_pt   o_pt
);

    typedef struct packed {
        t_pt  pt;
        t_fix x2;
        t_fix y2;
        t_fix xy;
    } t_s1;

    typedef struct packed {
        t_pt  pt;
        t_fix xy;
        t_fix r2;
        t_fix x2d;
        t_fix y2d;
    } t_s2;

    typedef struct packed {
        t_pt  pt;
        t_fix r2;
        t_fix a;
        t_fix rxx;
        t_fix ryy;
        t_fix pxy1;
        t_fix pxy2;
    } t_s3;

    typedef struct packed {
        t_pt  pt;
        t_fix r2;
        t_fix t1;
        t_fix dxa;
        t_fix dyb;
        t_fix mdx;
        t_fix mdy;
    } t_s4;

    typedef struct packed {
        t_pt  pt;
        t_fix t2;
        t_fix dx;
        t_fix dy;
    } t_s5;

    typedef struct packed {
        t_pt              pt;
        t_fix             nx;
        t_fix             ny;
        logic             sat;
        logic [DW-1:0]    den;
        logic [QBITS-1:0] rem;
        logic [QBITS-1:0] q;
    } t_dv;

    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    t_s4  r_s4, n_s4;
    t_s5  r_s5, n_s5;
    t_dv  r_dv [QBITS+1];
    t_dv  n_dv0;
    t_pt  r_out, n_out;
    logic [4:0] r_v;
    logic [QBITS:0] r_dv_v;
    logic r_out_v;
    t_fix den;

    always_comb begin
        n_s1.pt = i_pt;
        n_s1.x2 = fmul(i_pt.x, i_pt.x);
        n_s1.y2 = fmul(i_pt.y, i_pt.y);
        n_s1.xy = fmul(i_pt.x, i_pt.y);

        n_s2.pt  = r_s1.pt;
        n_s2.xy  = r_s1.xy;
        n_s2.r2  = fadd(r_s1.x2, r_s1.y2);
        n_s2.x2d = fadd(r_s1.x2, r_s1.x2);
        n_s2.y2d = fadd(r_s1.y2, r_s1.y2);

        n_s3.pt   = r_s2.pt;
        n_s3.r2   = r_s2.r2;
        n_s3.a    = fmul(i_coef.k3, r_s2.r2);
        n_s3.rxx  = fadd(r_s2.r2, r_s2.x2d);
        n_s3.ryy  = fadd(r_s2.r2, r_s2.y2d);
        n_s3.pxy1 = fmul(i_coef.p1, r_s2.xy);
        n_s3.pxy2 = fmul(i_coef.p2, r_s2.xy);

        n_s4.pt  = r_s3.pt;
        n_s4.r2  = r_s3.r2;
        n_s4.t1  = fmul(fadd(r_s3.a, i_coef.k2), r_s3.r2);
        n_s4.dxa = fadd(r_s3.pxy1, r_s3.pxy1);
        n_s4.dyb = fadd(r_s3.pxy2, r_s3.pxy2);
        n_s4.mdx = fmul(i_coef.p2, r_s3.rxx);
        n_s4.mdy = fmul(i_coef.p1, r_s3.ryy);

        n_s5.pt = r_s4.pt;
        n_s5.t2 = fmul(fadd(r_s4.t1, i_coef.k1), r_s4.r2);
        n_s5.dx = fadd(r_s4.dxa, r_s4.mdx);
        n_s5.dy = fadd(r_s4.mdy, r_s4.dyb);

        // denominator check; a non-positive value forces the fallback
        den         = fadd(FIX_ONE, r_s5.t2);
        n_dv0.pt    = r_s5.pt;
        if (!r_s5.pt.skip && !r_s5.pt.fb && (den[DW-1] || den == '0)) begin
            n_dv0.pt.fb = 1'b1;
        end
        n_dv0.nx  = fsub(r_s5.pt.x0, r_s5.dx);
        n_dv0.ny  = fsub(r_s5.pt.y0, r_s5.dy);
        n_dv0.sat = (den <= (t_fix'(1) <<< DIV_LO));
        n_dv0.den = den;
        n_dv0.rem = QBITS'(1) << DIV_LO;
        n_dv0.q   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_s4  <= n_s4;
            r_s5  <= n_s5;
            r_dv[0] <= n_dv0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (i_ce) begin
            r_dv_v[0] <= r_v[4];
        end
    end

    // restoring divide of 2^(2F) by den, one quotient bit per stage
    for (genvar k = 1; k <= QBITS; k++) begin : g_div
        logic [DW-1:0] w_t;
        t_dv           w_n;

        always_comb begin
            w_t = {r_dv[k-1].rem, 1'b0};
            w_n = r_dv[k-1];
            if (w_t >= r_dv[k-1].den) begin
                w_n.rem = QBITS'(w_t - r_dv[k-1].den);
                w_n.q   = {r_dv[k-1].q[QBITS-2:0], 1'b1};
            end else begin
                w_n.rem = w_t[QBITS-1:0];
                w_n.q   = {r_dv[k-1].q[QBITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_dv[k] <= w_n;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k] <= 1'b0;
            end else if (i_ce) begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
        end
    end

    always_comb begin
        t_fix ic;
        ic    = r_dv[QBITS].sat ? FIX_MAX : t_fix'({1'b0, r_dv[QBITS].q});
        n_out = r_dv[QBITS].pt;
        if (r_dv[QBITS].pt.fb) begin
            n_out.x = r_dv[QBITS].pt.x0;
            n_out.y = r_dv[QBITS].pt.y0;
        end else if (!r_dv[QBITS].pt.skip) begin
            n_out.x = fmul(r_dv[QBITS].nx, ic);
            n_out.y = fmul(r_dv[QBITS].ny, ic);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_ce) begin
            r_out_v <= r_dv_v[QBITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_pt    = r_out;

endmodule

// ===== bench/undistort_checker.sv =====
// ----------------------------------------------------------------------------
// undistort_checker: scoreboard for the lens undistortion block
// Watches the input and output streams, computes the undistorted point for
// every accepted input and compares it with the next output in order.
// ----------------------------------------------------------------------------
module undistort_checker
    import lud_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [DW-1:0]     i_cfg_data,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [2*DW-1:0]   i_s_tdata,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [2*DW-1:0]   i_m_tdata,
    input  logic              i_m_tuser,
    output int                o_errors,
    output int                o_pending,
    output int                o_points,
    output int                o_fallbacks
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DW-1:0] x;
        logic [DW-1:0] y;
        logic          fb;
    } t_point_out;

    longint coef_q[5];
    t_point_out undist_q[$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clamp32(p >>> FRAC_BITS);
    endfunction

    function automatic longint qadd(input longint a, input longint b);
        return clamp32(a + b);
    endfunction

    function automatic t_point_out undistort(input logic [DW-1:0] xin, input logic [DW-1:0] yin);
        longint x0, y0, x, y, x2, y2, xy, r2, t, den, ic, dx, dy;
        t_point_out r;
        x0 = longint'($signed(xin));
        y0 = longint'($signed(yin));
        x = x0;
        y = y0;
        r.fb = 1'b0;
        if (coef_q[0] != 0 || coef_q[1] != 0 || coef_q[2] != 0 ||
            coef_q[3] != 0 || coef_q[4] != 0) begin
            for (int it = 0; it < ITERATIONS; it++) begin
                x2 = qmul(x, x);
                y2 = qmul(y, y);
                xy = qmul(x, y);
                r2 = qadd(x2, y2);
                t = qadd(qmul(coef_q[REG_K3], r2), coef_q[REG_K2]);
                t = qadd(qmul(t, r2), coef_q[REG_K1]);
                t = qmul(t, r2);
                den = qadd(64'sd1 <<< FRAC_BITS, t);
                if (den <= 0) begin
                    x = x0;
                    y = y0;
                    r.fb = 1'b1;
                    break;
                end
                ic = clamp32((64'sd1 <<< (2 * FRAC_BITS)) / den);
                dx = qadd(qadd(qmul(coef_q[REG_P1], xy), qmul(coef_q[REG_P1], xy)),
                          qmul(coef_q[REG_P2], qadd(r2, qadd(x2, x2))));
                dy = qadd(qmul(coef_q[REG_P1], qadd(r2, qadd(y2, y2))),
                          qadd(qmul(coef_q[REG_P2], xy), qmul(coef_q[REG_P2], xy)));
                x = qmul(qadd(x0, -dx), ic);
                y = qmul(qadd(y0, -dy), ic);
            end
        end
        r.x = x[DW-1:0];
        r.y = y[DW-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_point_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) coef_q[i] = 0;
            o_errors <= 0;
            o_pending <= 0;
            o_points <= 0;
            o_fallbacks <= 0;
        end else begin
            // output side first: an input accepted now cannot come out this edge
            if (i_m_tvalid && i_m_tready) begin
                o_points <= o_points + 1;
                if (undist_q.size() == 0) begin
                    $display("%0t: unexpected output transaction x=%h y=%h fb=%b",
                             $time, i_m_tdata[DW-1:0], i_m_tdata[2*DW-1:DW], i_m_tuser);
                    o_errors <= o_errors + 1;
                end else begin
                    want = undist_q.pop_front();
                    if (want.fb) o_fallbacks <= o_fallbacks + 1;
                    if (i_m_tdata[DW-1:0] !== want.x || i_m_tdata[2*DW-1:DW] !== want.y ||
                        i_m_tuser !== want.fb) begin
                        $display("%0t: mismatch expected x=%h y=%h fb=%b actual x=%h y=%h fb=%b",
                                 $time, want.x, want.y, want.fb, i_m_tdata[DW-1:0],
                                 i_m_tdata[2*DW-1:DW], i_m_tuser);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                undist_q = {undist_q, undistort(i_s_tdata[DW-1:0], i_s_tdata[2*DW-1:DW])};
            if (i_cfg_we && i_cfg_addr < 5)
                coef_q[i_cfg_addr] = longint'($signed(i_cfg_data));
            o_pending <= undist_q.size();
        end
    end
endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for lens_undistort_point_iterative
// Runs directed points and random point streams across several coefficient
// sets with random gaps and stalls on both sides; the checker scores results.
// ----------------------------------------------------------------------------
module testbench;
    import lud_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = ITERATIONS * ITER_LAT + 1;
    localparam int WDOG_MAX  = 4 * LATENCY + 2000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [DW-1:0]     i_cfg_data;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [2*DW-1:0]   i_s_tdata;      // [31:0] x_in, [63:32] y_in
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [2*DW-1:0]   o_m_tdata;      // [31:0] x_out, [63:32] y_out
    logic              o_m_tuser;      // [0] fell_back

    int errors, pending, points, fallbacks;
    int sent;
    int idle_cycles;
    bit hold_off;       // long receiver stall request
    bit sink_quiet;     // receiver runs with no gaps

    lens_undistort_point_iterative dut (.*);

    undistort_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tuser  (o_m_tuser),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_points   (points),
        .o_fallbacks(fallbacks)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: cycles with no transaction on either stream
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stall per transaction, or a long hold-off on request
    initial begin
        int gap;
        i_m_tready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                i_m_tready <= 1'b0;
                repeat (3 * LATENCY) @(posedge i_clk);
                hold_off = 1'b0;
            end
            gap = sink_quiet ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk iff o_m_tvalid);
        end
    end

    task automatic write_coef(input t_reg_idx idx, input logic [DW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_coefs(input logic [DW-1:0] k1, k2, p1, p2, k3);
        write_coef(REG_K1, k1);
        write_coef(REG_K2, k2);
        write_coef(REG_P1, p1);
        write_coef(REG_P2, p2);
        write_coef(REG_K3, k3);
    endtask

    // one point, with an optional random gap ahead of it
    task automatic send_point(input logic [DW-1:0] x, input logic [DW-1:0] y, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {y, x};
        @(posedge i_clk iff o_s_tready);
        sent++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk iff pending == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // typical normalized coordinate: |v| below about 1.5
    function automatic logic [DW-1:0] near_point();
        return DW'($signed($urandom_range(0, 50331648)) - 25165824);
    endfunction

    function automatic logic [DW-1:0] any_point();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return DW'($signed($urandom_range(0, 4096)) - 2048);
            default: return near_point();
        endcase
    endfunction

    // small coefficient, |c| below about 0.5
    function automatic logic [DW-1:0] mild_coef();
        return DW'($signed($urandom_range(0, 16777216)) - 8388608);
    endfunction

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 60 < 15) sink_quiet = 1'b1;
            else sink_quiet = 1'b0;
            send_point(any_point(), any_point(), (i % 50) >= 10);
        end
        sink_quiet = 1'b0;
        drain();
    endtask

    initial begin
        logic [DW-1:0] edge_val[8];
        sent = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        sink_quiet = 1'b0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_addr <= '0;
        i_cfg_data <= '0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        edge_val = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                     32'h0100_0000, 32'hff00_0000, 32'h0080_0000, 32'h0000_0001};

        // all-zero coefficients: identity, including field extremes
        for (int i = 0; i < 8; i++) send_point(edge_val[i], edge_val[7 - i], 1'b0);
        drain();

        // realistic barrel distortion; extremes saturate or fall back
        load_coefs(32'hff99_999a, 32'h0019_999a, 32'h0000_4189, 32'hffff_be77, 32'h0002_0c4a);
        for (int i = 0; i < 8; i++) send_point(edge_val[i], edge_val[(i + 3) % 8], 1'b0);
        // large-radius point; the k2 and k3 terms keep the denominator positive here
        send_point(32'h0200_0000, 32'h0200_0000, 1'b0);
        drain();

        // coefficient extremes: fallback and saturation paths
        load_coefs(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        for (int i = 0; i < 8; i++) send_point(edge_val[i], edge_val[i], 1'b0);
        drain();

        // long receiver hold-off while the sender keeps offering
        load_coefs(mild_coef(), mild_coef(), mild_coef(), mild_coef(), mild_coef());
        hold_off = 1'b1;
        for (int i = 0; i < 2 * LATENCY; i++) send_point(near_point(), near_point(), 1'b0);
        drain();

        // random phases through several coefficient sets
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: load_coefs(mild_coef(), mild_coef(), 32'h0, 32'h0, 32'h0);
                1: load_coefs(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                              32'h8000_0000, 32'h7fff_ffff);
                2: load_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                3: load_coefs(32'h0, 32'h0, mild_coef(), mild_coef(), 32'h0);
                4: load_coefs(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
                default: load_coefs(mild_coef(), mild_coef(), mild_coef(),
                                    mild_coef(), mild_coef());
            endcase
            random_run(150);
        end

        $display("Sent %0d points, %0d results checked, %0d fallback results.",
                 sent, points, fallbacks);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
